// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the indexed list unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define IIRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define IIRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/iirl_pkg.sv =====
// Package with types and constants of the indexed list unit.
package iirl_pkg;

  localparam int DATA_W           = 32;
  localparam int OP_W             = 3;
  localparam int POS_W            = 7;
  localparam int CNT_OUT_W        = 7;
  localparam int DEFAULT_CAPACITY = 64;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_READ      = 3'd1,
    OP_INSERT    = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_OVERWRITE = 3'd4,
    OP_CLEAR     = 3'd5
  } opcode_e;

  // What every storage cell does with its entry in this cycle.
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_INSERT,
    MODE_REMOVE,
    MODE_WRITE
  } cell_mode_e;

  // What every cell does with its slot of the read chain.
  typedef enum logic [1:0] {
    RD_HOLD,
    RD_LOAD,
    RD_SHIFT
  } rd_mode_e;

  typedef struct packed {
    cell_mode_e        mode;
    rd_mode_e          rd;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== rtl/iirl_cell.sv =====
// One storage cell of the list: an entry register and a slot of the read chain.
module iirl_cell #(
  parameter int CAPACITY = iirl_pkg::DEFAULT_CAPACITY,
  parameter int IDX      = 0
) (
  input  logic                         clk_i,
  input  iirl_pkg::cell_ctrl_t         ctrl_i,
  input  logic [$clog2(CAPACITY+1)-1:0] idx_i,
  input  logic [iirl_pkg::DATA_W-1:0]  left_i,
  input  logic [iirl_pkg::DATA_W-1:0]  right_i,
  input  logic [iirl_pkg::DATA_W-1:0]  rd_right_i,
  output logic [iirl_pkg::DATA_W-1:0]  entry_o,
  output logic [iirl_pkg::DATA_W-1:0]  rd_o
);
  import iirl_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] MyIdx = CntW'(IDX);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic [DATA_W-1:0] rd_q, rd_d;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.mode)
      MODE_INSERT: begin
        if (MyIdx == idx_i) begin
          entry_d = ctrl_i.value;
        end else if (MyIdx > idx_i) begin
          entry_d = left_i;
        end
      end
      MODE_REMOVE: begin
        if (MyIdx >= idx_i) begin
          entry_d = right_i;
        end
      end
      MODE_WRITE: begin
        if (MyIdx == idx_i) begin
          entry_d = ctrl_i.value;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  // The read chain snapshots the entries before they move, then walks
  // one cell per cycle toward cell zero.
  always_comb begin
    rd_d = rd_q;
    case (ctrl_i.rd)
      RD_LOAD:  rd_d = entry_q;
      RD_SHIFT: rd_d = rd_right_i;
      default:  rd_d = rd_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    rd_q    <= rd_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = rd_q;

endmodule

// ===== rtl/indexed_insert_remove_list_unit.sv =====
// Top level of the indexed list unit: control, count and the row of cells.
// Append, insert, overwrite, clear and every failed request need no seek: a new
// request may follow in the next cycle, and its result strobe comes in the cycle
// after it is accepted. A successful read or remove at index p keeps busy high
// while the read chain moves the selected entry one cell per cycle down to cell
// zero, and its result is registered from cell zero once the entry is there. Each
// result is on the outputs for one cycle only, marked by result_valid_o; the receiver
// cannot stall it, so it must take every strobe. Entries have no reset; the fill
// count resets to zero.
module indexed_insert_remove_list_unit #(
  parameter int CAPACITY = iirl_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [iirl_pkg::OP_W-1:0]           opcode_i,
  input  logic [iirl_pkg::POS_W-1:0]          position_i,
  input  logic signed [iirl_pkg::DATA_W-1:0]  value_in_i,
  output logic                                result_valid_o,
  output logic signed [iirl_pkg::DATA_W-1:0]  value_out_o,
  output logic                                success_o,
  output logic [iirl_pkg::CNT_OUT_W-1:0]      entry_count_o
);
  import iirl_pkg::*;

  `include "assert_macros.svh"

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > POS_W) ? CntW : POS_W;
  localparam logic [CntW-1:0] Full = CntW'(CAPACITY);

  typedef enum logic {
    ST_IDLE,
    ST_SEEK
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   steps_q;
  logic              valid_q;
  logic              success_q;
  logic [DATA_W-1:0] value_q;

  logic              accept;
  logic              ok;
  logic              seek_req;
  logic [CmpW-1:0]   pos_x, cnt_x;
  logic              full;
  cell_ctrl_t        ctrl;
  logic [CntW-1:0]   idx;

  logic [DATA_W-1:0] entry_w [CAPACITY];
  logic [DATA_W-1:0] rd_w    [CAPACITY];

  assign accept = start && (state_q == ST_IDLE);
  assign pos_x  = CmpW'(position_i);
  assign cnt_x  = CmpW'(count_q);
  assign full   = (count_q == Full);

  always_comb begin
    ok        = 1'b0;
    seek_req  = 1'b0;
    count_d   = count_q;
    ctrl.mode = MODE_HOLD;
    idx       = CntW'(position_i);
    case (opcode_e'(opcode_i))
      OP_APPEND: begin
        ok        = !full;
        idx       = count_q;
        ctrl.mode = MODE_INSERT;
        count_d   = count_q + 1'b1;
      end
      OP_READ: begin
        ok       = (pos_x < cnt_x);
        seek_req = 1'b1;
      end
      OP_INSERT: begin
        ok        = (pos_x <= cnt_x) && !full;
        ctrl.mode = MODE_INSERT;
        count_d   = count_q + 1'b1;
      end
      OP_REMOVE: begin
        ok        = (pos_x < cnt_x);
        seek_req  = 1'b1;
        ctrl.mode = MODE_REMOVE;
        count_d   = count_q - 1'b1;
      end
      OP_OVERWRITE: begin
        ok        = (pos_x < cnt_x);
        ctrl.mode = MODE_WRITE;
      end
      OP_CLEAR: begin
        ok      = 1'b1;
        count_d = '0;
      end
      default: ok = 1'b0;
    endcase
    if (!(accept && ok)) begin
      ctrl.mode = MODE_HOLD;
      count_d   = count_q;
    end
    if (accept && ok && seek_req) begin
      ctrl.rd = RD_LOAD;
    end else if (state_q == ST_SEEK && steps_q != '0) begin
      ctrl.rd = RD_SHIFT;
    end else begin
      ctrl.rd = RD_HOLD;
    end
    ctrl.value = value_in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      steps_q   <= '0;
      valid_q   <= 1'b0;
      success_q <= 1'b0;
      value_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            count_q   <= count_d;
            success_q <= ok;
            value_q   <= '0;
            if (ok && seek_req) begin
              state_q <= ST_SEEK;
              steps_q <= idx;
            end else begin
              valid_q <= 1'b1;
            end
          end
        end
        ST_SEEK: begin
          if (steps_q == '0) begin
            state_q <= ST_IDLE;
            valid_q <= 1'b1;
            value_q <= rd_w[0];
          end else begin
            steps_q <= steps_q - 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left, right, rd_right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right    = '0;
      assign rd_right = '0;
    end else begin : g_inner
      assign right    = entry_w[i+1];
      assign rd_right = rd_w[i+1];
    end
    iirl_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .idx_i      (idx),
      .left_i     (left),
      .right_i    (right),
      .rd_right_i (rd_right),
      .entry_o    (entry_w[i]),
      .rd_o       (rd_w[i])
    );
  end

  assign busy           = (state_q == ST_SEEK);
  assign result_valid_o = valid_q;
  assign value_out_o    = value_q;
  assign success_o      = success_q;
  assign entry_count_o  = CNT_OUT_W'(count_q);

  `IIRL_ASSERT_ALWAYS(a_count_bound, count_q <= Full, "fill count above capacity")
  `IIRL_ASSERT(a_no_strobe_busy, busy |-> !result_valid_o, "result strobe while busy")
  `IIRL_ASSERT(a_count_stable, busy |=> $stable(count_q), "fill count moved during a seek")
  `IIRL_ASSERT(a_fail_zero, result_valid_o && !success_o |-> value_out_o == '0,
               "failed request returned nonzero data")
  `IIRL_ASSERT(a_seek_steps, busy && steps_q != '0 |=> busy && steps_q == $past(steps_q) - 1'b1,
               "read chain counter skipped")

endmodule
